FILE: rtl/core/gtp_pkg.sv
// Package for the Goertzel tone power core: field widths, derived datapath widths,
// state and register index codes, and the command word of the serial multiplier.
// Depends on nothing; every file of the core imports it.
package gtp_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int STATE_WIDTH     = 40;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC       = 14;
   localparam int SCALE_WIDTH     = 32;
   localparam int POWER_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int PROD_WIDTH      = STATE_WIDTH + COEF_WIDTH;
   localparam int ROUND_WIDTH     = PROD_WIDTH + 1 - COEF_FRAC;
   localparam int SUM_WIDTH       = ROUND_WIDTH + 1;
   localparam int CROSS_WIDTH     = STATE_WIDTH + PROD_WIDTH;
   localparam int SQUARE_WIDTH    = 2 * STATE_WIDTH;
   localparam int Q_WIDTH         = CROSS_WIDTH;
   localparam int MCAND_WIDTH     = (STATE_WIDTH > SCALE_WIDTH) ? STATE_WIDTH : SCALE_WIDTH + 1;
   localparam int MPLR_WIDTH      = Q_WIDTH;
   localparam int MUL_COUNT_WIDTH = $clog2(MPLR_WIDTH + 1);
   localparam int FULL_WIDTH      = MCAND_WIDTH + MPLR_WIDTH;
   localparam int POWER_SHIFT     = COEF_FRAC + SCALE_WIDTH;

   localparam logic signed [PROD_WIDTH:0] ROUND_HALF = (PROD_WIDTH + 1)'(2 ** (COEF_FRAC - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_REC,
      ST_UPDATE,
      ST_DIFF,
      ST_MUL_CROSS,
      ST_MUL_SQUARE,
      ST_MUL_SCALE,
      ST_EMIT
   } gtp_state_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COEFFICIENT = CSR_INDEX_WIDTH'(0),
      CSR_POWER_SCALE = CSR_INDEX_WIDTH'(1)
   } gtp_csr_index_type;

   typedef struct packed {
      logic                       start;
      logic [MUL_COUNT_WIDTH-1:0] length;
   } gtp_mul_cmd_type;

endpackage

FILE: rtl/core/gtp_serial_mul.sv
// Serial-parallel signed multiplier: one multiplier bit per cycle, product shifted in
// from the top of the multiplier register. Depends on gtp_pkg.
// The final step of a run gives its bit negative weight (two's complement multiplier).
module gtp_serial_mul
   import gtp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  gtp_mul_cmd_type               mul_cmd,
   input  logic signed [MCAND_WIDTH-1:0] mcand,
   input  logic signed [MPLR_WIDTH-1:0]  mplr,
   output logic                          mul_busy,
   output logic [FULL_WIDTH-1:0]         product
);

   logic signed [MCAND_WIDTH-1:0] hi_ff;
   logic signed [MCAND_WIDTH-1:0] hi_in;
   logic [MPLR_WIDTH-1:0]         lo_ff;
   logic [MPLR_WIDTH-1:0]         lo_in;
   logic signed [MCAND_WIDTH-1:0] mcand_ff;
   logic [MUL_COUNT_WIDTH-1:0]    count_ff;
   logic [MUL_COUNT_WIDTH-1:0]    count_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic                          step_last;
   logic signed [MCAND_WIDTH:0]   mcand_ext;
   logic signed [MCAND_WIDTH:0]   addend;
   logic signed [MCAND_WIDTH:0]   step_sum;

   always_comb begin
      step_last = (count_ff == MUL_COUNT_WIDTH'(1));
      mcand_ext = (MCAND_WIDTH + 1)'(mcand_ff);
      if (lo_ff[0]) begin
         addend = step_last ? -mcand_ext : mcand_ext;
      end else begin
         addend = '0;
      end
      step_sum = (MCAND_WIDTH + 1)'(hi_ff) + addend;
      hi_in    = step_sum[MCAND_WIDTH:1];
      lo_in    = {step_sum[0], lo_ff[MPLR_WIDTH-1:1]};
   end

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (mul_cmd.start) begin
         count_in = mul_cmd.length;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         count_in = count_ff - MUL_COUNT_WIDTH'(1);
         busy_in  = !step_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_cmd.start) begin
         hi_ff    <= '0;
         lo_ff    <= mplr;
         mcand_ff <= mcand;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign mul_busy = busy_ff;
   assign product  = {hi_ff, lo_ff};

endmodule

FILE: rtl/core/goertzel_tone_power_core.sv
// Goertzel single-tone power detector: top level with control sequencer and datapath.
// Depends on gtp_pkg and gtp_serial_mul.
//
// Usage: audio samples arrive as words on the req_ channel (valid/ready), each with a
// flag that marks the last sample of a block. Every sample advances the recurrence
// s0 = sample + coefficient*s1 - s2 (Q2.14 coefficient, 40-bit saturating state).
// A last sample also forms the tone power s0^2 + s1^2 - coefficient*s0*s1, scales it
// by power_scale, and sends one saturated 32-bit word on the rsp_ channel; the state
// then clears. The csr_ channel writes coefficient (index 0) and power_scale (index 1)
// and is always ready; write only while the core is idle.
// A sample is accepted only while the core is idle, after the previous one is done;
// the 16-bit coefficient passes one bit per cycle through the serial multiplier.
// A last sample then runs the multiplier with 56-, 40- and 96-bit multipliers for the
// cross term, the square term and the scaling before its result is registered.
// The result register holds a finished word while the receiver stalls; a new block may
// be accepted meanwhile, and its own result waits until that word is taken.
// Reset clears both registers, the state and any pending result.
module goertzel_tone_power_core
   import gtp_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [POWER_WIDTH-1:0]     rsp_power,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   gtp_state_type                 state_ff;
   gtp_state_type                 state_in;
   logic signed [COEF_WIDTH-1:0]  coefficient_ff;
   logic signed [COEF_WIDTH-1:0]  coefficient_in;
   logic [SCALE_WIDTH-1:0]        power_scale_ff;
   logic [SCALE_WIDTH-1:0]        power_scale_in;
   logic signed [STATE_WIDTH-1:0] prev_value_ff;
   logic signed [STATE_WIDTH-1:0] prev_value_in;
   logic signed [STATE_WIDTH-1:0] prev_prev_value_ff;
   logic signed [STATE_WIDTH-1:0] prev_prev_value_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic                          last_ff;
   logic signed [STATE_WIDTH-1:0] s0_ff;
   logic signed [Q_WIDTH-1:0]     q_ff;
   logic [POWER_WIDTH-1:0]        power_ff;

   gtp_mul_cmd_type               mul_cmd;
   logic signed [MCAND_WIDTH-1:0] mul_mcand;
   logic signed [MPLR_WIDTH-1:0]  mul_mplr;
   logic                          mul_busy;
   logic [FULL_WIDTH-1:0]         product;

   logic                          req_fire;
   logic                          emit_fire;
   logic signed [PROD_WIDTH-1:0]  rec_prod;
   logic signed [PROD_WIDTH:0]    round_full;
   logic signed [ROUND_WIDTH-1:0] round_w;
   logic signed [SUM_WIDTH-1:0]   sum_w;
   logic signed [STATE_WIDTH-1:0] s0_w;
   logic signed [PROD_WIDTH-1:0]  diff_w;
   logic signed [Q_WIDTH-1:0]     cross_w;
   logic signed [SQUARE_WIDTH-1:0] square_w;
   logic signed [Q_WIDTH-1:0]     q_sum;
   logic                          power_over;
   logic [POWER_WIDTH-1:0]        power_w;

   gtp_serial_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_cmd  (mul_cmd),
      .mcand    (mul_mcand),
      .mplr     (mul_mplr),
      .mul_busy (mul_busy),
      .product  (product)
   );

   // Datapath arithmetic around the multiplier.
   always_comb begin
      rec_prod   = product[MPLR_WIDTH - COEF_WIDTH +: PROD_WIDTH];
      round_full = (PROD_WIDTH + 1)'(rec_prod) + ROUND_HALF;
      round_w    = ROUND_WIDTH'(round_full >>> COEF_FRAC);
      sum_w      = SUM_WIDTH'(round_w) + SUM_WIDTH'(sample_ff) - SUM_WIDTH'(prev_prev_value_ff);
      if (sum_w[SUM_WIDTH-1:STATE_WIDTH-1] == '0 || sum_w[SUM_WIDTH-1:STATE_WIDTH-1] == '1) begin
         s0_w = sum_w[STATE_WIDTH-1:0];
      end else if (sum_w[SUM_WIDTH-1]) begin
         s0_w = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
      end else begin
         s0_w = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
      end
      diff_w     = (PROD_WIDTH'(s0_ff) <<< COEF_FRAC) - rec_prod;
      cross_w    = product[MPLR_WIDTH - PROD_WIDTH +: CROSS_WIDTH];
      square_w   = product[MPLR_WIDTH - STATE_WIDTH +: SQUARE_WIDTH];
      q_sum      = q_ff + (Q_WIDTH'(square_w) <<< COEF_FRAC);
      power_over = |product[FULL_WIDTH-1:POWER_SHIFT + POWER_WIDTH];
      power_w    = power_over ? '1 : product[POWER_SHIFT +: POWER_WIDTH];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_REC;
            end
         end
         ST_MUL_REC: begin
            if (!mul_busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = last_ff ? ST_DIFF : ST_IDLE;
         end
         ST_DIFF: begin
            state_in = ST_MUL_CROSS;
         end
         ST_MUL_CROSS: begin
            if (!mul_busy) begin
               state_in = ST_MUL_SQUARE;
            end
         end
         ST_MUL_SQUARE: begin
            if (!mul_busy) begin
               state_in = ST_MUL_SCALE;
            end
         end
         ST_MUL_SCALE: begin
            if (!mul_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs: handshakes and multiplier commands.
   always_comb begin
      req_ready      = 1'b0;
      emit_fire      = 1'b0;
      mul_cmd.start  = 1'b0;
      mul_cmd.length = MUL_COUNT_WIDTH'(COEF_WIDTH);
      mul_mcand      = MCAND_WIDTH'(prev_value_ff);
      mul_mplr       = MPLR_WIDTH'(coefficient_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            mul_cmd.start = req_valid;
         end
         ST_DIFF: begin
            mul_cmd.start  = 1'b1;
            mul_cmd.length = MUL_COUNT_WIDTH'(PROD_WIDTH);
            mul_mcand      = MCAND_WIDTH'(s0_ff);
            mul_mplr       = MPLR_WIDTH'(diff_w);
         end
         ST_MUL_CROSS: begin
            mul_cmd.start  = !mul_busy;
            mul_cmd.length = MUL_COUNT_WIDTH'(STATE_WIDTH);
            mul_mplr       = MPLR_WIDTH'(prev_value_ff);
         end
         ST_MUL_SQUARE: begin
            mul_cmd.start  = !mul_busy;
            mul_cmd.length = MUL_COUNT_WIDTH'(MPLR_WIDTH);
            mul_mcand      = MCAND_WIDTH'({1'b0, power_scale_ff});
            mul_mplr       = q_sum;
         end
         ST_EMIT: begin
            emit_fire = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      coefficient_in     = coefficient_ff;
      power_scale_in     = power_scale_ff;
      prev_value_in      = prev_value_ff;
      prev_prev_value_in = prev_prev_value_ff;
      rsp_valid_in       = emit_fire || (rsp_valid_ff && !rsp_ready);
      if (csr_valid) begin
         case (csr_index)
            CSR_COEFFICIENT: coefficient_in = csr_data[COEF_WIDTH-1:0];
            CSR_POWER_SCALE: power_scale_in = csr_data[SCALE_WIDTH-1:0];
            default:         coefficient_in = coefficient_ff;
         endcase
      end
      if (state_ff == ST_UPDATE && !last_ff) begin
         prev_value_in      = s0_w;
         prev_prev_value_in = prev_value_ff;
      end
      if (emit_fire) begin
         prev_value_in      = '0;
         prev_prev_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         coefficient_ff     <= '0;
         power_scale_ff     <= '0;
         prev_value_ff      <= '0;
         prev_prev_value_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         coefficient_ff     <= coefficient_in;
         power_scale_ff     <= power_scale_in;
         prev_value_ff      <= prev_value_in;
         prev_prev_value_ff <= prev_prev_value_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_sample;
         last_ff   <= req_last_sample;
      end
      if (state_ff == ST_UPDATE) begin
         s0_ff <= s0_w;
      end
      if (state_ff == ST_MUL_CROSS && !mul_busy) begin
         q_ff <= cross_w;
      end
      if (emit_fire) begin
         power_ff <= power_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = power_ff;

`ifndef ASSERT_OFF
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("Result word appeared outside the emit step.");

   a_ready_mul_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mul_busy)
      else $error("Input ready while the multiplier is still running.");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (prev_value_ff == '0 && prev_prev_value_ff == '0 && rsp_valid))
      else $error("State not cleared or result not presented after a block.");
`endif

endmodule

FILE: tb/goertzel_tone_power_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for goertzel_tone_power_core: a directed table, then random
// blocks checked against a bit-exact tone power predictor.
// Depends on gtp_pkg and the core RTL only.
module goertzel_tone_power_core_tb;
   import gtp_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 9;
   localparam int WIDE = 192;
   localparam int RECUR_ROUND = 1 << (COEF_FRAC - 1);
   localparam int DRAIN_CYCLES = 250;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 136;
   localparam int MAX_REPORTS = 10;
   localparam logic [31:0] RUN_LIMIT = 32'd2_000_000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOP_INDEX = '1;

   typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PATTERN}
      ready_mode_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [CSR_INDEX_WIDTH-1:0]      idx;
      logic [CSR_DATA_WIDTH-1:0]       data;
      logic signed [SAMPLE_WIDTH-1:0]  smp;
      logic                            lst;
      logic                            typed;
      logic [POWER_WIDTH-1:0]          want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_WIDTH-1:0] req_sample = '0;
   logic req_last_sample = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [POWER_WIDTH-1:0] rsp_power;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   logic signed [COEF_WIDTH-1:0] tone_coef = '0;
   logic [SCALE_WIDTH-1:0] tone_scale = '0;
   logic signed [STATE_WIDTH-1:0] tone_s1 = '0;
   logic signed [STATE_WIDTH-1:0] tone_s2 = '0;
   logic [POWER_WIDTH-1:0] power_due[$];
   logic [POWER_WIDTH-1:0] power_front;
   int mismatch_count = 0;
   logic [31:0] cycle_count = '0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   bit drain_due = 1'b0;
   logic hold_request = 1'b0;
   logic hold_served = 1'b0;
   int hold_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;

   row_type directed_rows [32] = '{
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_WRITE, CSR_POWER_SCALE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b1, 1'b1, 32'h3FFF_FFFF},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 1'b1, 32'h3FFF_0000},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_WRITE, CSR_COEFFICIENT, 32'h0000_7FFF, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_COEFFICIENT, 32'h0000_8000, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_TOP_INDEX, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
      '{ROW_WRITE, CSR_SPARE_INDEX, 32'h0000_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0001, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_POWER_SCALE, 32'h0000_0001, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh3039, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_COEFFICIENT, 32'hFFFF_C000, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'shFFFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0001, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_POWER_SCALE, 32'h0040_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0064, 1'b1, 1'b0, '0},
      '{ROW_WRITE, CSR_COEFFICIENT, 32'h0000_0000, '0, 1'b0, 1'b0, '0},
      '{ROW_SAMPLE, '0, '0, 16'sh0000, 1'b1, 1'b0, '0}
   };

   goertzel_tone_power_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power(rsp_power),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      if (cycle_count == RUN_LIMIT) begin
         $display("goertzel_tone_power_core test failed");
         $finish;
      end
   end

   // Advances the recurrence by one sample; on the last sample of a block it returns the
   // scaled, saturated tone power and clears the state.
   function automatic logic tone_step(input logic signed [SAMPLE_WIDTH-1:0] smp,
                                      input logic lst, output logic [POWER_WIDTH-1:0] pw);
      logic signed [WIDE-1:0] acc;
      logic signed [WIDE-1:0] hi_lim;
      logic signed [WIDE-1:0] lo_lim;
      logic signed [WIDE-1:0] a;
      logic signed [WIDE-1:0] b;
      logic signed [WIDE-1:0] q;
      logic signed [STATE_WIDTH-1:0] s0;
      acc = (WIDE'(tone_coef) * WIDE'(tone_s1) + WIDE'(RECUR_ROUND)) >>> COEF_FRAC;
      acc = acc + WIDE'(smp) - WIDE'(tone_s2);
      hi_lim = (WIDE'(1) <<< (STATE_WIDTH - 1)) - WIDE'(1);
      lo_lim = -hi_lim - WIDE'(1);
      if (acc > hi_lim) s0 = hi_lim[STATE_WIDTH-1:0];
      else if (acc < lo_lim) s0 = lo_lim[STATE_WIDTH-1:0];
      else s0 = acc[STATE_WIDTH-1:0];
      pw = '0;
      if (!lst) begin
         tone_s2 = tone_s1;
         tone_s1 = s0;
         return 1'b0;
      end
      a = WIDE'(s0);
      b = WIDE'(tone_s1);
      q = ((a * a + b * b) <<< COEF_FRAC) - WIDE'(tone_coef) * a * b;
      q = (q * WIDE'($signed({1'b0, tone_scale}))) >>> POWER_SHIFT;
      if (q[WIDE-1]) pw = '0;
      else if (|q[WIDE-1:POWER_WIDTH]) pw = '1;
      else pw = q[POWER_WIDTH-1:0];
      tone_s1 = '0;
      tone_s2 = '0;
      return 1'b1;
   endfunction

   task automatic put_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic lst,
                             input logic typed = 1'b0, input logic [POWER_WIDTH-1:0] want = '0);
      logic [POWER_WIDTH-1:0] pw;
      req_valid <= 1'b1;
      req_sample <= smp;
      req_last_sample <= lst;
      do @(posedge clock); while (!req_ready);
      if (tone_step(smp, lst, pw)) power_due.push_back(typed ? want : pw);
      drain_due = 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   endtask

   // Registers change only with the core idle: every result taken and the datapath quiet.
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      if (req_valid) req_valid <= 1'b0;
      while (power_due.size() != 0) @(posedge clock);
      if (drain_due) repeat (DRAIN_CYCLES) @(posedge clock);
      drain_due = 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COEFFICIENT: tone_coef = val[COEF_WIDTH-1:0];
         CSR_POWER_SCALE: tone_scale = val[SCALE_WIDTH-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic report_mismatch(input logic [POWER_WIDTH-1:0] want,
                                  input logic [POWER_WIDTH-1:0] got, input bit orphan);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         if (orphan) $display("unexpected power word %h at cycle %0d", got, cycle_count);
         else $display("power mismatch at cycle %0d: expected %h, got %h", cycle_count, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (power_due.size() == 0) begin
            report_mismatch('0, rsp_power, 1'b1);
         end else begin
            power_front = power_due.pop_front();
            if (power_front !== rsp_power) report_mismatch(power_front, rsp_power, 1'b0);
         end
      end
   end

   // The receiver stalls on a mode that is redrawn at random, plus one long hold-off.
   always @(posedge clock) begin
      if (cycle_count[8:0] == 0) ready_mode <= ready_mode_type'($urandom_range(0, 3));
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request && !hold_served) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_served <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_HALF: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= cycle_count[2] ^ cycle_count[4];
         endcase
      end
   end

   initial begin
      logic [CSR_DATA_WIDTH-1:0] cfg;
      logic signed [SAMPLE_WIDTH-1:0] smp;
      logic signed [SAMPLE_WIDTH-1:0] level;
      int items;
      int blk;
      int style;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            write_reg(directed_rows[r].idx, directed_rows[r].data);
         end else begin
            put_sample(directed_rows[r].smp, directed_rows[r].lst, directed_rows[r].typed,
                       directed_rows[r].want);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         cfg = $urandom;
         case ($urandom_range(0, 5))
            0: cfg[COEF_WIDTH-1:0] = 16'h7FFF;
            1: cfg[COEF_WIDTH-1:0] = 16'h8000;
            2: cfg[COEF_WIDTH-1:0] = 16'h0000;
            default: ;
         endcase
         write_reg(CSR_COEFFICIENT, cfg);
         case ($urandom_range(0, 4))
            0: cfg = '0;
            1: cfg = '1;
            2, 3: cfg = 32'h8000_0000 >> $urandom_range(0, 12);
            default: cfg = $urandom;
         endcase
         write_reg(CSR_POWER_SCALE, cfg);
         if ($urandom_range(0, 2) == 0) write_reg(CSR_INDEX_WIDTH'($urandom_range(2, 255)), $urandom);
         gaps_on = (phase % 3 != 2);
         if (phase == 1) hold_request <= 1'b1;
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            blk = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 16);
            style = $urandom_range(0, 3);
            level = SAMPLE_WIDTH'($urandom);
            for (int i = 0; i < blk; i++) begin
               case (style)
                  0: smp = SAMPLE_WIDTH'($urandom);
                  1: smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  2: smp = SAMPLE_WIDTH'($urandom_range(0, 32)) - 16'sd16;
                  default: smp = level;
               endcase
               put_sample(smp, i == blk - 1);
               items++;
            end
         end
      end

      if (req_valid) req_valid <= 1'b0;
      while (power_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("goertzel_tone_power_core test passed");
      end else begin
         $display("goertzel_tone_power_core test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/gtp_pkg.sv
rtl/core/gtp_serial_mul.sv
rtl/core/goertzel_tone_power_core.sv
tb/goertzel_tone_power_core_tb.sv
